>>> design/strip_vertical_extent_core_macros.svh
// Assertion macros used by the queue of the strip vertical extent core.
`ifndef STRIP_VERTICAL_EXTENT_CORE_MACROS_SVH
`define STRIP_VERTICAL_EXTENT_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, clocked on clock, off during reset.
`define SVE_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define SVE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SVE_ASSERT_IMPL(lbl, ante, cons, msg)
`define SVE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> design/sve_pkg.sv
// Types, constants and the threshold function of the strip vertical extent core.
package sve_pkg;

   // Parameter defaults
   localparam int DEF_SEGMENTS  = 100;
   localparam int DEF_MAX_ROWS  = 1024;
   localparam int DEF_MAX_WIDTH = 4096;

   // Field widths
   localparam int PIXEL_W   = 8;
   localparam int MODE_W    = 3;
   localparam int FWIDTH_W  = 13;
   localparam int SWIDTH_W  = 6;
   localparam int EXT_W     = 10;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [PIXEL_W-1:0] FULL_LEVEL = 8'd255;
   localparam logic [EXT_W-1:0]   EXTENT_MAX = 10'd1023;

   // Register reset values
   localparam logic [PIXEL_W-1:0]  RST_LEVEL  = 8'd55;
   localparam logic [MODE_W-1:0]   RST_MODE   = 3'd0;
   localparam logic [FWIDTH_W-1:0] RST_FWIDTH = 13'd640;
   localparam logic [SWIDTH_W-1:0] RST_SWIDTH = 6'd6;

   // Front-to-back queue depth
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [MODE_W-1:0] {
      MODE_BINARY      = 3'd0,
      MODE_INVERTED    = 3'd1,
      MODE_TRUNCATE    = 3'd2,
      MODE_TOZERO      = 3'd3,
      MODE_TOZERO_INV  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      CSR_LEVEL        = 2'd0,
      CSR_MODE         = 2'd1,
      CSR_FRAME_WIDTH  = 2'd2,
      CSR_STRIP_WIDTH  = 2'd3
   } csr_addr_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_value;
      logic               frame_end;
   } req_data_type;

   typedef struct packed {
      logic [EXT_W-1:0] largest_extent;
      logic             any_hit;
   } rsp_data_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]  threshold_level;
      logic [MODE_W-1:0]   threshold_mode;
      logic [FWIDTH_W-1:0] frame_width;
      logic [SWIDTH_W-1:0] strip_width;
   } cfg_type;

   // Thresholded value of one pixel; unused mode codes act as binary.
   function automatic logic [PIXEL_W-1:0] thresholded(input logic [PIXEL_W-1:0] v,
                                                      input logic [PIXEL_W-1:0] t,
                                                      input logic [MODE_W-1:0]  mode);
      logic above;
      above = (v > t);
      case (mode)
         MODE_INVERTED:   thresholded = above ? '0 : FULL_LEVEL;
         MODE_TRUNCATE:   thresholded = above ? t : v;
         MODE_TOZERO:     thresholded = above ? v : '0;
         MODE_TOZERO_INV: thresholded = above ? '0 : v;
         default:         thresholded = above ? FULL_LEVEL : '0;
      endcase
   endfunction

endpackage

>>> design/sve_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sve_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                    wdata,
   input  logic                                re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                    rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> design/sve_front.sv
// Front part: thresholds each pixel and tracks column, strip and row position.
module sve_front #(
   parameter int SEGMENTS  = sve_pkg::DEF_SEGMENTS,
   parameter int MAX_ROWS  = sve_pkg::DEF_MAX_ROWS,
   parameter int MAX_WIDTH = sve_pkg::DEF_MAX_WIDTH,
   parameter int ITEM_W    = 3 + (SEGMENTS > 1 ? $clog2(SEGMENTS) : 1) + $clog2(MAX_ROWS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sve_pkg::cfg_type      cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sve_pkg::req_data_type req_data,
   input  logic                  q_full,
   output logic                  q_push,
   output logic [ITEM_W-1:0]     q_item
);
   import sve_pkg::*;

   localparam int SEG_AW  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int SIDX_W  = $clog2(SEGMENTS + 1);
   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int CMP_W   = (COL_W + 1 > FWIDTH_W) ? COL_W + 1 : FWIDTH_W;

   typedef struct packed {
      logic              last;
      logic              hit;
      logic              tracked;
      logic [SEG_AW-1:0] strip_addr;
      logic [ROW_W-1:0]  row;
   } item_type;

   logic [COL_W-1:0]    col_ff,   col_in;
   logic [ROW_W-1:0]    row_ff,   row_in;
   logic [SIDX_W-1:0]   sidx_ff,  sidx_in;
   logic [SWIDTH_W-1:0] cis_ff,   cis_in;

   logic [CMP_W-1:0]    fw_eff;
   logic [SWIDTH_W-1:0] sw_eff;
   logic                row_wrap;
   logic                strip_wrap;
   item_type            item;

   assign req_stall = q_full;
   assign q_push    = req_valid && !req_stall;

   always_comb begin
      fw_eff = CMP_W'(cfg.frame_width);
      if (cfg.frame_width == '0) begin
         fw_eff = CMP_W'(1);
      end else if (CMP_W'(cfg.frame_width) > CMP_W'(MAX_WIDTH)) begin
         fw_eff = CMP_W'(MAX_WIDTH);
      end
      sw_eff = (cfg.strip_width == '0) ? SWIDTH_W'(1) : cfg.strip_width;
      row_wrap   = (CMP_W'(col_ff) + CMP_W'(1)) >= fw_eff;
      strip_wrap = ({1'b0, cis_ff} + (SWIDTH_W + 1)'(1)) >= {1'b0, sw_eff};
   end

   always_comb begin
      item.last       = req_data.frame_end;
      item.hit        = thresholded(req_data.pixel_value, cfg.threshold_level,
                                    cfg.threshold_mode) == '0;
      item.tracked    = sidx_ff < SIDX_W'(SEGMENTS);
      item.strip_addr = sidx_ff[SEG_AW-1:0];
      item.row        = row_ff;
      q_item          = item;
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      sidx_in = sidx_ff;
      cis_in  = cis_ff;
      if (q_push) begin
         if (row_wrap) begin
            col_in  = '0;
            cis_in  = '0;
            sidx_in = '0;
            if (row_ff != ROW_W'(MAX_ROWS - 1)) begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
            if (strip_wrap) begin
               cis_in = '0;
               if (sidx_ff < SIDX_W'(SEGMENTS)) begin
                  sidx_in = sidx_ff + SIDX_W'(1);
               end
            end else begin
               cis_in = cis_ff + SWIDTH_W'(1);
            end
         end
         if (req_data.frame_end) begin
            col_in  = '0;
            row_in  = '0;
            sidx_in = '0;
            cis_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         sidx_ff <= '0;
         cis_ff  <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         sidx_ff <= sidx_in;
         cis_ff  <= cis_in;
      end
   end

endmodule

>>> design/sve_queue.sv
// Short queue between the front and back parts.
module sve_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = sve_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   import sve_pkg::*;

   `include "strip_vertical_extent_core_macros.svh"

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `SVE_ASSERT_IMPL(a_no_push_when_full, push, count_ff != CNT_W'(DEPTH), "push into full queue")
   `SVE_ASSERT_IMPL(a_no_pop_when_empty, pop, count_ff != '0, "pop from empty queue")
   `SVE_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CNT_W'(DEPTH), "queue count over depth")
   `SVE_ASSERT_NEXT(a_count_grows, push && !pop, count_ff == $past(count_ff) + CNT_W'(1), "count did not grow")

endmodule

>>> design/sve_back.sv
// Back part: per-strip first-row store, running extent maximum and result register.
module sve_back #(
   parameter int SEGMENTS = sve_pkg::DEF_SEGMENTS,
   parameter int MAX_ROWS = sve_pkg::DEF_MAX_ROWS,
   parameter int ITEM_W   = 3 + (SEGMENTS > 1 ? $clog2(SEGMENTS) : 1) + $clog2(MAX_ROWS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  logic [ITEM_W-1:0]     q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sve_pkg::rsp_data_type rsp_data
);
   import sve_pkg::*;

   localparam int SEG_AW    = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int EXT_CMP_W = (ROW_W > EXT_W) ? ROW_W : EXT_W;

   typedef struct packed {
      logic              last;
      logic              hit;
      logic              tracked;
      logic [SEG_AW-1:0] strip_addr;
      logic [ROW_W-1:0]  row;
   } item_type;

   logic          advance;
   item_type      s1_item_ff, s1_item_in;
   logic          s1_valid_ff, s1_valid_in;
   item_type      s2_item_ff, s2_item_in;
   logic          s2_valid_ff, s2_valid_in;
   logic          s2_ext_ok_ff, s2_ext_ok_in;
   logic [SEGMENTS-1:0] seen_ff, seen_in;
   logic [EXT_W-1:0] largest_ff, largest_in;
   logic          hit_ff, hit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_data_type  rsp_data_ff, rsp_data_in;

   logic             s1_go;
   logic             s1_track_hit;
   logic             s1_was_seen;
   logic             ram_we;
   logic             ram_re;
   logic [ROW_W-1:0] first_row;
   logic [ROW_W-1:0] ext_raw;
   logic [EXT_CMP_W-1:0] ext_wide;
   logic [EXT_W-1:0] ext_sat;
   logic [EXT_W-1:0] cand;
   logic             hit_new;

   // Hold the whole back part only when a finished frame result cannot be placed.
   assign advance = !(s2_valid_ff && s2_item_ff.last && rsp_valid_ff && rsp_stall);
   assign q_pop   = advance && q_valid;

   always_comb begin
      s1_item_in  = s1_item_ff;
      s1_valid_in = s1_valid_ff;
      s2_item_in  = s2_item_ff;
      s2_valid_in = s2_valid_ff;
      if (advance) begin
         s1_item_in  = item_type'(q_item);
         s1_valid_in = q_valid;
         s2_item_in  = s1_item_ff;
         s2_valid_in = s1_valid_ff;
      end
   end

   // Stage 1: record the first row of a strip, or fetch it for an extent.
   always_comb begin
      s1_go        = advance && s1_valid_ff;
      s1_track_hit = s1_item_ff.hit && s1_item_ff.tracked;
      s1_was_seen  = seen_ff[s1_item_ff.strip_addr];
      ram_we       = s1_go && s1_track_hit && !s1_was_seen;
      ram_re       = s1_go && s1_track_hit && s1_was_seen;
      seen_in      = seen_ff;
      s2_ext_ok_in = s2_ext_ok_ff;
      if (s1_go) begin
         s2_ext_ok_in = s1_track_hit && s1_was_seen;
         if (ram_we) begin
            seen_in[s1_item_ff.strip_addr] = 1'b1;
         end
         if (s1_item_ff.last) begin
            seen_in = '0;
         end
      end else if (advance) begin
         s2_ext_ok_in = 1'b0;
      end
   end

   sve_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SEGMENTS)
   ) u_first_row (
      .clock (clock),
      .we    (ram_we),
      .waddr (s1_item_ff.strip_addr),
      .wdata (s1_item_ff.row),
      .re    (ram_re),
      .raddr (s1_item_ff.strip_addr),
      .rdata (first_row)
   );

   // Stage 2: extent, running maximum and frame result.
   always_comb begin
      ext_raw  = s2_item_ff.row - first_row;
      ext_wide = EXT_CMP_W'(ext_raw);
      ext_sat  = (ext_wide > EXT_CMP_W'(EXTENT_MAX)) ? EXTENT_MAX : ext_wide[EXT_W-1:0];
      cand     = (s2_ext_ok_ff && (ext_sat > largest_ff)) ? ext_sat : largest_ff;
      hit_new  = hit_ff || s2_item_ff.hit;

      largest_in   = largest_ff;
      hit_in       = hit_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance && s2_valid_ff) begin
         if (s2_item_ff.last) begin
            rsp_data_in.largest_extent = cand;
            rsp_data_in.any_hit        = hit_new;
            rsp_valid_in               = 1'b1;
            largest_in                 = '0;
            hit_in                     = 1'b0;
         end else begin
            largest_in = cand;
            hit_in     = hit_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff   <= s1_item_in;
      s2_item_ff   <= s2_item_in;
      s2_ext_ok_ff <= s2_ext_ok_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         seen_ff      <= '0;
         largest_ff   <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         seen_ff      <= seen_in;
         largest_ff   <= largest_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> design/strip_vertical_extent_core.sv
// Top level of the strip vertical extent core: CSR block, front, queue and back parts.
// A frame-end pixel's result passes the queue, stage 1, stage 2 and then the result register.
// Throughput: one pixel per cycle; the front stalls only when the 4-entry queue fills
//   behind a frame result that waits in the output register while the next one is ready.
// Reset (synchronous, active high) loads the register defaults, clears counters, strip
//   seen bits, running maximum and result valid; the first-row RAM needs no clearing.
module strip_vertical_extent_core #(
   parameter int SEGMENTS  = sve_pkg::DEF_SEGMENTS,
   parameter int MAX_ROWS  = sve_pkg::DEF_MAX_ROWS,
   parameter int MAX_WIDTH = sve_pkg::DEF_MAX_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Pixel channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  sve_pkg::req_data_type                req_data,
   // Result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output sve_pkg::rsp_data_type                rsp_data,
   // Register port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [sve_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [sve_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [sve_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);
   import sve_pkg::*;

   localparam int SEG_AW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int ITEM_W = 3 + SEG_AW + $clog2(MAX_ROWS);

   logic [PIXEL_W-1:0]  level_ff,  level_in;
   logic [MODE_W-1:0]   mode_ff,   mode_in;
   logic [FWIDTH_W-1:0] fwidth_ff, fwidth_in;
   logic [SWIDTH_W-1:0] swidth_ff, swidth_in;
   logic                csr_write;
   cfg_type             cfg;

   logic                q_push;
   logic [ITEM_W-1:0]   q_push_item;
   logic                q_full;
   logic                q_pop;
   logic                q_head_valid;
   logic [ITEM_W-1:0]   q_head_item;

   // Register file: pready is tied high, a write lands at the access phase of the transfer.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      level_in  = level_ff;
      mode_in   = mode_ff;
      fwidth_in = fwidth_ff;
      swidth_in = swidth_ff;
      if (csr_write) begin
         case (paddr[3:2])
            CSR_LEVEL:       level_in  = pwdata[PIXEL_W-1:0];
            CSR_MODE:        mode_in   = pwdata[MODE_W-1:0];
            CSR_FRAME_WIDTH: fwidth_in = pwdata[FWIDTH_W-1:0];
            CSR_STRIP_WIDTH: swidth_in = pwdata[SWIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         CSR_LEVEL:       prdata = CSR_DATA_W'(level_ff);
         CSR_MODE:        prdata = CSR_DATA_W'(mode_ff);
         CSR_FRAME_WIDTH: prdata = CSR_DATA_W'(fwidth_ff);
         CSR_STRIP_WIDTH: prdata = CSR_DATA_W'(swidth_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= RST_LEVEL;
         mode_ff   <= RST_MODE;
         fwidth_ff <= RST_FWIDTH;
         swidth_ff <= RST_SWIDTH;
      end else begin
         level_ff  <= level_in;
         mode_ff   <= mode_in;
         fwidth_ff <= fwidth_in;
         swidth_ff <= swidth_in;
      end
   end

   always_comb begin
      cfg.threshold_level = level_ff;
      cfg.threshold_mode  = mode_ff;
      cfg.frame_width     = fwidth_ff;
      cfg.strip_width     = swidth_ff;
   end

   // Front: threshold and position tracking, one pixel per transfer.
   sve_front #(
      .SEGMENTS  (SEGMENTS),
      .MAX_ROWS  (MAX_ROWS),
      .MAX_WIDTH (MAX_WIDTH),
      .ITEM_W    (ITEM_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_push_item)
   );

   // Queue: decouple the front from stalls of the result channel.
   sve_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head_item)
   );

   // Back: strip store update, extent maximum and result register.
   sve_back #(
      .SEGMENTS (SEGMENTS),
      .MAX_ROWS (MAX_ROWS),
      .ITEM_W   (ITEM_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_head_valid),
      .q_item    (q_head_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
